// ----- hw/rtl/pid_pkg.sv -----
// Shared types and constants for the positional insert/delete array.
package pid_pkg;

  localparam int unsigned FUNC_W        = 2;
  localparam int unsigned POS_W         = 7;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned LEN_W         = 5;
  localparam int unsigned DEPTH_DEFAULT = 16;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BADPOS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic                     upd;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;
  } pid_cmd_t;

endpackage

// ----- hw/rtl/pid_if.sv -----
// Valid/ready channel interfaces for requests and results.
interface pid_in_if;
  logic                              valid;
  logic                              ready;
  logic [pid_pkg::FUNC_W-1:0]        func;
  logic [pid_pkg::POS_W-1:0]         position;
  logic signed [pid_pkg::DATA_W-1:0] value;

  modport source (output valid, output func, output position, output value, input ready);
  modport sink   (input valid, input func, input position, input value, output ready);
endinterface

interface pid_out_if;
  logic                              valid;
  logic                              ready;
  logic [pid_pkg::STATUS_W-1:0]      status;
  logic signed [pid_pkg::DATA_W-1:0] read_value;
  logic [pid_pkg::LEN_W-1:0]         length;

  modport source (output valid, output status, output read_value, output length, input ready);
  modport sink   (input valid, input status, input read_value, input length, output ready);
endinterface

// ----- hw/rtl/positional_insert_delete_array.sv -----
// Top level of the positional insert/delete array.
// An ordered list of up to DEPTH signed 32-bit elements held in a row of
// cells, one element per cell. Every request (insert, delete, update, read)
// is applied at once: all cells shift or load together on the edge that
// accepts it, so one request per clock is sustained unless the result stalls.
// The result is registered and appears the cycle after acceptance; a new
// request is taken whenever the result register is empty or being drained.
// Element storage has no reset; only the length and handshake state clear.
module positional_insert_delete_array #(
  parameter int unsigned DEPTH = pid_pkg::DEPTH_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pid_in_if.sink    in_i,
  pid_out_if.source out_o
);

  localparam int unsigned PosW  = pid_pkg::POS_W;
  localparam int unsigned LenW  = pid_pkg::LEN_W;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned IdxW  = $clog2(DEPTH);
  localparam int unsigned CmpW  = (CntW > PosW) ? CntW : PosW;
  localparam logic [CmpW-1:0] DepthCmp = CmpW'(DEPTH);

  logic [CntW-1:0] count_d, count_q;
  logic            accept;
  logic [CmpW-1:0] pos_ext, cnt_ext;
  logic [pid_pkg::STATUS_W-1:0] status;
  logic signed [pid_pkg::DATA_W-1:0] rd_value;
  pid_pkg::pid_cmd_t cmd;

  logic signed [pid_pkg::DATA_W-1:0] elem [DEPTH];

  logic                              out_valid_d, out_valid_q;
  logic [pid_pkg::STATUS_W-1:0]      out_status_q;
  logic signed [pid_pkg::DATA_W-1:0] out_rd_q;
  logic [LenW-1:0]                   out_len_q;
  logic [CntW+LenW-1:0]              len_ext;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign pos_ext = CmpW'(in_i.position);
  assign cnt_ext = CmpW'(count_q);

  always_comb begin
    status    = pid_pkg::STATUS_OK;
    cmd.ins   = 1'b0;
    cmd.del   = 1'b0;
    cmd.upd   = 1'b0;
    cmd.pos   = in_i.position;
    cmd.value = in_i.value;
    rd_value  = '0;
    count_d   = count_q;
    if (in_i.func == pid_pkg::FUNC_INSERT) begin
      if (pos_ext > cnt_ext) begin
        status = pid_pkg::STATUS_BADPOS;
      end else if (cnt_ext >= DepthCmp) begin
        status = pid_pkg::STATUS_FULL;
      end else begin
        cmd.ins = accept;
        count_d = count_q + CntW'(1);
      end
    end else if (pos_ext >= cnt_ext) begin
      status = pid_pkg::STATUS_BADPOS;
    end else begin
      case (in_i.func)
        pid_pkg::FUNC_DELETE: begin
          cmd.del = accept;
          count_d = count_q - CntW'(1);
        end
        pid_pkg::FUNC_UPDATE: cmd.upd = accept;
        default:              rd_value = elem[in_i.position[IdxW-1:0]];
      endcase
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic signed [pid_pkg::DATA_W-1:0] left, right;
      if (gi == 0) begin : g_first
        assign left = in_i.value;
      end else begin : g_mid_l
        assign left = elem[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right = elem[gi];
      end else begin : g_mid_r
        assign right = elem[gi+1];
      end
      pid_cell #(
        .IDX (gi)
      ) u_cell (
        .clk_i        (clk_i),
        .cmd_i        (cmd),
        .data_left_i  (left),
        .data_right_i (right),
        .data_o       (elem[gi])
      );
    end
  endgenerate

  assign len_ext     = {LenW'(0), count_d};
  assign out_valid_d = accept || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_status_q <= status;
      out_rd_q     <= rd_value;
      out_len_q    <= len_ext[LenW-1:0];
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.read_value = out_rd_q;
  assign out_o.length     = out_len_q;

endmodule

// ----- hw/rtl/pid_cell.sv -----
// One storage cell of the row: holds, loads, or takes a neighbor's element.
module pid_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                              clk_i,
  input  pid_pkg::pid_cmd_t                 cmd_i,
  input  logic signed [pid_pkg::DATA_W-1:0] data_left_i,
  input  logic signed [pid_pkg::DATA_W-1:0] data_right_i,
  output logic signed [pid_pkg::DATA_W-1:0] data_o
);

  localparam int unsigned PosW = pid_pkg::POS_W;
  localparam logic [PosW-1:0] MyIdx = PosW'(IDX);

  logic signed [pid_pkg::DATA_W-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (cmd_i.pos == MyIdx) begin
        data_d = cmd_i.value;
      end else if (cmd_i.pos < MyIdx) begin
        data_d = data_left_i;
      end
    end else if (cmd_i.del) begin
      if (cmd_i.pos <= MyIdx) begin
        data_d = data_right_i;
      end
    end else if (cmd_i.upd) begin
      if (cmd_i.pos == MyIdx) begin
        data_d = cmd_i.value;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ----- hw/rtl/pid_checker.sv -----
// Port-level assertions for the positional insert/delete array, with bind.
module pid_checker #(
  parameter int unsigned DEPTH = pid_pkg::DEPTH_DEFAULT
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [pid_pkg::STATUS_W-1:0]      out_status,
  input logic signed [pid_pkg::DATA_W-1:0] out_read_value,
  input logic [pid_pkg::LEN_W-1:0]         out_length
);

  localparam logic [pid_pkg::LEN_W-1:0] DepthLen = pid_pkg::LEN_W'(DEPTH);

  // result stalled: no new transaction may enter
  a_no_accept_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("request accepted while result stalled");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status)
      && $stable(out_read_value) && $stable(out_length)))
    else $error("stalled result changed");

  a_rd_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_status != pid_pkg::STATUS_OK) |-> (out_read_value == '0))
    else $error("nonzero read value on error status");

  a_full_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_status == pid_pkg::STATUS_FULL) |-> (out_length == DepthLen))
    else $error("full status with length below depth");

  // accepted request always yields a result next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted request produced no result");

endmodule

bind positional_insert_delete_array pid_checker #(
  .DEPTH (DEPTH)
) u_pid_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid       (in_i.valid),
  .in_ready       (in_i.ready),
  .out_valid      (out_o.valid),
  .out_ready      (out_o.ready),
  .out_status     (out_o.status),
  .out_read_value (out_o.read_value),
  .out_length     (out_o.length)
);

// ----- test/positional_insert_delete_array_tb.sv -----
// Testbench for the positional insert/delete array: random and directed requests, scoreboard.
`timescale 1ns / 1ps

module positional_insert_delete_array_tb;

  localparam int unsigned DEPTH      = pid_pkg::DEPTH_DEFAULT;
  localparam int unsigned HOLD_LEN   = 120;
  localparam int unsigned HOLD_AFTER = 300;
  localparam int unsigned CYCLE_MAX  = 200000;
  localparam int unsigned RAND_ITEMS = 826;

  typedef struct packed {
    logic                              drain_first;
    logic [pid_pkg::FUNC_W-1:0]        func;
    logic [pid_pkg::POS_W-1:0]         position;
    logic signed [pid_pkg::DATA_W-1:0] value;
  } list_req_t;

  typedef struct packed {
    logic [pid_pkg::STATUS_W-1:0]      status;
    logic signed [pid_pkg::DATA_W-1:0] read_value;
    logic [pid_pkg::LEN_W-1:0]         length;
  } list_rsp_t;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_e;

  logic clk_i;
  logic rst_ni;

  pid_in_if  in_if ();
  pid_out_if out_if ();

  positional_insert_delete_array #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  list_req_t request_q[$];
  list_rsp_t expected_q[$];

  // predictor state
  logic signed [pid_pkg::DATA_W-1:0] list_mem[DEPTH];
  int unsigned                       list_len;

  // stimulus-side length tracker, used only to shape positions
  int unsigned gen_len;

  int unsigned offered_cnt;
  int unsigned accepted_cnt;
  int unsigned results_cnt;
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned send_gap;
  int unsigned rsp_wait;
  int unsigned rsp_seen;
  int unsigned hold_cycles;
  logic        hold_on;
  logic        hold_done;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic list_rsp_t predict_request(list_req_t req);
    list_rsp_t   rsp;
    int unsigned idx;
    rsp.status     = pid_pkg::STATUS_OK;
    rsp.read_value = '0;
    if (req.func == pid_pkg::FUNC_INSERT) begin
      if (req.position > list_len) begin
        rsp.status = pid_pkg::STATUS_BADPOS;
      end else if (list_len >= DEPTH) begin
        rsp.status = pid_pkg::STATUS_FULL;
      end else begin
        for (idx = list_len; idx > req.position; idx--) list_mem[idx] = list_mem[idx-1];
        list_mem[req.position] = req.value;
        list_len++;
      end
    end else if (req.position >= list_len) begin
      rsp.status = pid_pkg::STATUS_BADPOS;
    end else if (req.func == pid_pkg::FUNC_DELETE) begin
      for (idx = req.position; idx + 1 < list_len; idx++) list_mem[idx] = list_mem[idx+1];
      list_len--;
    end else if (req.func == pid_pkg::FUNC_UPDATE) begin
      list_mem[req.position] = req.value;
    end else begin
      rsp.read_value = list_mem[req.position];
    end
    rsp.length = list_len[pid_pkg::LEN_W-1:0];
    return rsp;
  endfunction

  task automatic add_request(logic [pid_pkg::FUNC_W-1:0] func, int unsigned pos,
                             logic [pid_pkg::DATA_W-1:0] value, bit drain = 1'b0);
    list_req_t req;
    req.drain_first = drain;
    req.func        = func;
    req.position    = pos[pid_pkg::POS_W-1:0];
    req.value       = value;
    request_q.push_back(req);
    if (func == pid_pkg::FUNC_INSERT) begin
      if (pos <= gen_len && gen_len < DEPTH) gen_len++;
    end else if (func == pid_pkg::FUNC_DELETE && pos < gen_len) begin
      gen_len--;
    end
  endtask

  function automatic logic [pid_pkg::DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return 32'h8000_0000;
    if (r < 6) return 32'h7FFF_FFFF;
    if (r < 8) return 32'h0;
    if (r < 10) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // mostly legal positions, some on the boundaries, some anywhere in the field
  function automatic int unsigned pick_position(logic [pid_pkg::FUNC_W-1:0] func);
    int unsigned r;
    int unsigned top;
    r   = $urandom_range(0, 99);
    top = (func == pid_pkg::FUNC_INSERT) ? gen_len : gen_len - 1;
    if (r < 10) return $urandom_range(0, (1 << pid_pkg::POS_W) - 1);
    if (r < 14) return gen_len + $urandom_range(0, 1);
    if (func != pid_pkg::FUNC_INSERT && gen_len == 0) return 0;
    if (r < 24) return ($urandom_range(0, 1) == 0) ? 0 : top;
    return $urandom_range(0, top);
  endfunction

  function automatic logic [pid_pkg::FUNC_W-1:0] pick_func(phase_e ph,
                                                           int unsigned ins_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < ins_pct) return pid_pkg::FUNC_INSERT;
    if (ph == PH_DRAIN && $urandom_range(0, 99) < 80) return pid_pkg::FUNC_DELETE;
    case ($urandom_range(0, 2))
      0: return pid_pkg::FUNC_DELETE;
      1: return pid_pkg::FUNC_UPDATE;
      default: return pid_pkg::FUNC_READ;
    endcase
  endfunction

  function automatic int unsigned idle_cycles(bit quiet);
    return quiet ? 0 : $urandom_range(0, 6);
  endfunction

  task automatic build_stimulus();
    phase_e                     ph;
    int unsigned                ins_pct;
    int unsigned                n;
    logic [pid_pkg::FUNC_W-1:0] func;
    gen_len = 0;
    // empty list: everything but insert at zero is out of range
    add_request(pid_pkg::FUNC_READ,   0,   32'h1234_5678);
    add_request(pid_pkg::FUNC_DELETE, 0,   32'h0);
    add_request(pid_pkg::FUNC_UPDATE, 0,   32'hDEAD_BEEF);
    add_request(pid_pkg::FUNC_INSERT, 1,   32'h1);
    add_request(pid_pkg::FUNC_INSERT, 127, 32'h2);
    // build [0, min, 0x55555555, max, -1] through front, middle and tail inserts
    add_request(pid_pkg::FUNC_INSERT, 0, 32'h8000_0000);
    add_request(pid_pkg::FUNC_INSERT, 1, 32'h7FFF_FFFF);
    add_request(pid_pkg::FUNC_INSERT, 0, 32'h0000_0000);
    add_request(pid_pkg::FUNC_INSERT, 3, 32'hFFFF_FFFF);
    add_request(pid_pkg::FUNC_INSERT, 2, 32'h5555_5555);
    for (int i = 0; i < 5; i++) add_request(pid_pkg::FUNC_READ, i, 32'hFFFF_FFFF);
    add_request(pid_pkg::FUNC_READ,   5,   32'h0);
    add_request(pid_pkg::FUNC_READ,   127, 32'h0);
    add_request(pid_pkg::FUNC_UPDATE, 4,   32'hAAAA_AAAA);
    add_request(pid_pkg::FUNC_UPDATE, 5,   32'h1111_1111);
    add_request(pid_pkg::FUNC_DELETE, 2,   32'h0);
    add_request(pid_pkg::FUNC_DELETE, 4,   32'h0);
    add_request(pid_pkg::FUNC_DELETE, 3,   32'h0);
    add_request(pid_pkg::FUNC_READ,   2,   32'h0);
    add_request(pid_pkg::FUNC_READ,   0,   32'h0);

    // random part in phases; first a fill to overflow, then a drain to empty
    n = 0;
    for (int blk = 0; n < RAND_ITEMS; blk++) begin
      if (blk == 0) begin
        ph      = PH_FILL;
        ins_pct = 85;
      end else if (blk == 1) begin
        ph      = PH_DRAIN;
        ins_pct = 10;
      end else begin
        case ($urandom_range(0, 2))
          0: begin ph = PH_FILL;  ins_pct = 80; end
          1: begin ph = PH_DRAIN; ins_pct = 15; end
          default: begin ph = PH_MIXED; ins_pct = $urandom_range(25, 60); end
        endcase
      end
      for (int k = 0; k < 40 && n < RAND_ITEMS; k++) begin
        func = pick_func(ph, ins_pct);
        add_request(func, pick_position(func), pick_value(), (n == 0 || n == 550));
        n++;
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.func     = pid_pkg::FUNC_INSERT;
    in_if.position = '0;
    in_if.value    = '0;
    out_if.ready   = 1'b0;
    list_len       = 0;
    offered_cnt    = 0;
    accepted_cnt   = 0;
    results_cnt    = 0;
    err_cnt        = 0;
    cycle_cnt      = 0;
    send_gap       = 0;
    rsp_wait       = 0;
    rsp_seen       = 0;
    hold_cycles    = 0;
    hold_on        = 1'b0;
    hold_done      = 1'b0;
    for (int i = 0; i < DEPTH; i++) list_mem[i] = '0;
    build_stimulus();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni && !(in_if.valid && accepted_cnt != offered_cnt)) begin
      if (in_if.valid) send_gap = idle_cycles(((offered_cnt / 80) % 4) == 3);
      if (send_gap > 0) begin
        send_gap--;
        in_if.valid <= 1'b0;
      end else if (request_q.size() > 0 &&
                   !(request_q[0].drain_first && expected_q.size() > 0)) begin
        in_if.valid    <= 1'b1;
        in_if.func     <= request_q[0].func;
        in_if.position <= request_q[0].position;
        in_if.value    <= request_q[0].value;
        void'(request_q.pop_front());
        offered_cnt++;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off so the block backs up onto its input
  always @(negedge clk_i) begin
    if (rst_ni && !hold_done) begin
      if (hold_on) begin
        hold_cycles <= hold_cycles + 1;
        if (hold_cycles == HOLD_LEN - 1) begin
          hold_on   <= 1'b0;
          hold_done <= 1'b1;
        end
      end else if (results_cnt >= HOLD_AFTER) begin
        hold_on <= 1'b1;
      end
    end
  end

  // result ready
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (results_cnt != rsp_seen) begin
        rsp_seen = results_cnt;
        rsp_wait = idle_cycles(((results_cnt / 90) % 4) == 2);
      end
      if (hold_on || rsp_wait > 0) begin
        out_if.ready <= 1'b0;
        if (!hold_on) rsp_wait--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // monitor and scoreboard
  always @(posedge clk_i) begin
    list_req_t req;
    list_rsp_t exp_rsp;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        req.drain_first = 1'b0;
        req.func        = in_if.func;
        req.position    = in_if.position;
        req.value       = in_if.value;
        expected_q.push_back(predict_request(req));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (out_if.valid && out_if.ready) begin
        results_cnt <= results_cnt + 1;
        if (expected_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("ERROR: unexpected result status=%0d read_value=%0d length=%0d",
                     out_if.status, out_if.read_value, out_if.length);
        end else begin
          exp_rsp = expected_q.pop_front();
          if (out_if.status !== exp_rsp.status || out_if.read_value !== exp_rsp.read_value ||
              out_if.length !== exp_rsp.length) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display({"ERROR: result %0d expected status=%0d read_value=%0d length=%0d,",
                        " got status=%0d read_value=%0d length=%0d"},
                       results_cnt, exp_rsp.status, exp_rsp.read_value, exp_rsp.length,
                       out_if.status, out_if.read_value, out_if.length);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_MAX) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    @(posedge rst_ni);
    while (request_q.size() > 0 || accepted_cnt != offered_cnt) @(posedge clk_i);
    while (expected_q.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
